// ===== rtl/core/sacache_pkg.sv =====
`timescale 1ns / 1ps
package sacache_pkg;

    localparam int MAX_WAYS   = 16;
    localparam int MAX_SETS   = 1024;
    localparam int ADDR_BITS  = 32;
    localparam int COUNT_BITS = 32;

    localparam int NBANK   = 2;
    localparam int WAY_AW  = $clog2(MAX_WAYS);
    localparam int WCNT_W  = WAY_AW + 1;
    localparam int SET_AW  = $clog2(MAX_SETS);
    localparam int ROWS    = NBANK * MAX_SETS;
    localparam int ROW_AW  = $clog2(ROWS);
    localparam int RANK_W  = 4;
    localparam int NCNT    = 8;
    localparam int PADDR_W = 5;

    // access kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;

    // replacement policies
    localparam logic [1:0] POL_LRU  = 2'd0;
    localparam logic [1:0] POL_FIFO = 2'd1;
    localparam logic [1:0] POL_RAND = 2'd2;

    // register indexes
    localparam logic [2:0] REG_SPLIT  = 3'd0;
    localparam logic [2:0] REG_POLICY = 3'd1;
    localparam logic [2:0] REG_WAYS   = 3'd2;
    localparam logic [2:0] REG_OFFSET = 3'd3;
    localparam logic [2:0] REG_USETS  = 3'd4;
    localparam logic [2:0] REG_ISETS  = 3'd5;
    localparam logic [2:0] REG_DSETS  = 3'd6;

    // event counter slots
    localparam int CNT_HIT       = 0;
    localparam int CNT_MISS      = 1;
    localparam int CNT_FETCH_HIT = 2;
    localparam int CNT_FETCH_MIS = 3;
    localparam int CNT_READ_HIT  = 4;
    localparam int CNT_READ_MIS  = 5;
    localparam int CNT_WRITE_HIT = 6;
    localparam int CNT_WRITE_MIS = 7;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic       split_mode;
        logic [1:0] replace_policy;
        logic [2:0] ways_log2;
        logic [3:0] offset_bits;
        logic [3:0] unified_sets_log2;
        logic [3:0] inst_sets_log2;
        logic [3:0] data_sets_log2;
    } t_cfg;

    typedef struct packed {
        logic              clr;
        logic [ROW_AW-1:0] clr_addr;
        logic              accept;
        logic              commit;
    } t_cmd;

    typedef struct packed {
        logic                 vld;
        logic [ADDR_BITS-1:0] tag;
        logic [RANK_W-1:0]    rank;
    } t_line;

    typedef struct packed {
        logic [WAY_AW-1:0]        fifo;
        t_line [MAX_WAYS-1:0]     line;
    } t_row;

endpackage

// ===== rtl/core/sacache_if.sv =====
`timescale 1ns / 1ps
interface sacache_acc_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] byte_address;
    modport source (output valid, output kind, output byte_address, input ready);
    modport sink   (input valid, input kind, input byte_address, output ready);
endinterface

interface sacache_res_if;
    logic        valid;
    logic        ready;
    logic        was_hit;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] fetch_hits;
    logic [31:0] fetch_misses;
    logic [31:0] read_hits;
    logic [31:0] read_misses;
    logic [31:0] write_hits;
    logic [31:0] write_misses;
    modport source (output valid, output was_hit, output total_hits, output total_misses,
                    output fetch_hits, output fetch_misses, output read_hits,
                    output read_misses, output write_hits, output write_misses,
                    input ready);
    modport sink   (input valid, input was_hit, input total_hits, input total_misses,
                    input fetch_hits, input fetch_misses, input read_hits,
                    input read_misses, input write_hits, input write_misses,
                    output ready);
endinterface

// ===== rtl/core/sacache_ram.sv =====
`timescale 1ns / 1ps
module sacache_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sacache_ctrl.sv =====
`timescale 1ns / 1ps
module sacache_ctrl
    import sacache_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [ROW_AW-1:0] r_clr_cnt, n_clr_cnt;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.clr_addr = r_clr_cnt;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == ROW_AW'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_LOOK;
                end
            end
            ST_LOOK: begin
                // wait until the result slot is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.commit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/sacache_dp.sv =====
`timescale 1ns / 1ps
module sacache_dp
    import sacache_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_cfg        i_cfg,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_byte_address,
    output logic        o_was_hit,
    output logic [31:0] o_cnt [NCNT]
);

    // access latched at accept
    logic [1:0]           r_kind;
    logic [ADDR_BITS-1:0] r_block;
    logic [ROW_AW-1:0]    r_row;
    logic                 r_was_hit;
    logic [15:0]          r_lfsr;
    logic [COUNT_BITS-1:0] r_cnt [NCNT];

    logic [ADDR_BITS-1:0] w_block;
    logic [ROW_AW-1:0]    w_row;
    t_row                 w_rd_row, w_wr_row;
    logic [ROW_AW-1:0]    w_waddr;
    logic [$bits(t_row)-1:0] w_rdata, w_wdata;

    // set index of the incoming access
    always_comb begin
        logic       bank;
        logic [3:0] slg;
        logic [31:0] sets;
        logic [31:0] set_full;
        bank     = i_cfg.split_mode && (i_kind == KIND_FETCH);
        slg      = i_cfg.split_mode ? (bank ? i_cfg.inst_sets_log2 : i_cfg.data_sets_log2)
                                    : i_cfg.unified_sets_log2;
        sets     = 32'd1 << slg;
        if (sets > 32'(MAX_SETS)) begin
            sets = 32'(MAX_SETS);
        end
        w_block  = ADDR_BITS'(i_byte_address >> i_cfg.offset_bits);
        set_full = 32'(w_block) & (sets - 32'd1);
        w_row    = {bank, set_full[SET_AW-1:0]};
    end

    sacache_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr | i_cmd.commit),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (w_row),
        .o_rdata (w_rdata)
    );

    assign w_rd_row = t_row'(w_rdata);
    assign w_waddr  = i_cmd.clr ? i_cmd.clr_addr : r_row;
    assign w_wdata  = i_cmd.clr ? '0 : w_wr_row;

    // lookup and line update on the row read back
    logic              w_hit;
    logic              w_evict;
    logic [15:0]       w_lfsr_nx;

    always_comb begin
        logic [31:0]       ways_full;
        logic [WCNT_W-1:0] ways;
        logic [WAY_AW-1:0] wmask;
        logic [MAX_WAYS-1:0] in_use, hv, ev, cand;
        logic              found;
        logic [WAY_AW-1:0] hw, fw, vw, w;
        logic [4:0]        old;
        ways_full = 32'd1 << i_cfg.ways_log2;
        if (ways_full > 32'(MAX_WAYS)) begin
            ways_full = 32'(MAX_WAYS);
        end
        ways      = ways_full[WCNT_W-1:0];
        wmask     = WAY_AW'(ways - 1'b1);
        w_lfsr_nx = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 16'd0);
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_use[i] = WCNT_W'(i) < ways;
            hv[i] = in_use[i] && w_rd_row.line[i].vld && (w_rd_row.line[i].tag == r_block);
            ev[i] = in_use[i] && !w_rd_row.line[i].vld;
            cand[i] = in_use[i];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (in_use[j] && (w_rd_row.line[j].rank > w_rd_row.line[i].rank)) begin
                    cand[i] = 1'b0;
                end
            end
        end
        hw = '0;
        fw = '0;
        vw = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (hv[i]) hw = WAY_AW'(i);
            if (ev[i]) fw = WAY_AW'(i);
            if (cand[i]) vw = WAY_AW'(i);
        end
        w_hit   = |hv;
        found   = |ev;
        w_evict = !w_hit && !found;
        if (i_cfg.replace_policy == POL_FIFO) begin
            vw = w_rd_row.fifo & wmask;
        end else if (i_cfg.replace_policy == POL_RAND) begin
            vw = w_lfsr_nx[WAY_AW-1:0] & wmask;
        end
        if (w_hit) begin
            w   = hw;
            old = {1'b0, w_rd_row.line[hw].rank};
        end else if (found) begin
            w   = fw;
            old = 5'd16;
        end else begin
            w   = vw;
            old = {1'b0, w_rd_row.line[vw].rank};
        end
        w_wr_row = w_rd_row;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (WAY_AW'(i) == w) begin
                w_wr_row.line[i].rank = '0;
                if (!w_hit) begin
                    w_wr_row.line[i].vld = 1'b1;
                    w_wr_row.line[i].tag = r_block;
                end
            end else if (in_use[i] && w_rd_row.line[i].vld
                         && ({1'b0, w_rd_row.line[i].rank} < old)
                         && (w_rd_row.line[i].rank != '1)) begin
                w_wr_row.line[i].rank = w_rd_row.line[i].rank + 1'b1;
            end
        end
        if (w_evict && (i_cfg.replace_policy == POL_FIFO)) begin
            w_wr_row.fifo = (w + 1'b1) & wmask;
        end
    end

    // which counters move
    logic [NCNT-1:0] w_bump;
    always_comb begin
        w_bump = '0;
        w_bump[CNT_HIT]       = w_hit;
        w_bump[CNT_MISS]      = !w_hit;
        w_bump[CNT_FETCH_HIT] = w_hit && (r_kind == KIND_FETCH);
        w_bump[CNT_FETCH_MIS] = !w_hit && (r_kind == KIND_FETCH);
        w_bump[CNT_READ_HIT]  = w_hit && (r_kind == KIND_READ);
        w_bump[CNT_READ_MIS]  = !w_hit && (r_kind == KIND_READ);
        w_bump[CNT_WRITE_HIT] = w_hit && (r_kind == KIND_WRITE);
        w_bump[CNT_WRITE_MIS] = !w_hit && (r_kind == KIND_WRITE);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_block <= w_block;
            r_row   <= w_row;
        end
        if (i_cmd.commit) begin
            r_was_hit <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LFSR_SEED;
            for (int j = 0; j < NCNT; j++) begin
                r_cnt[j] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (w_evict && (i_cfg.replace_policy == POL_RAND)) begin
                r_lfsr <= w_lfsr_nx;
            end
            for (int j = 0; j < NCNT; j++) begin
                if (w_bump[j] && (r_cnt[j] != '1)) begin
                    r_cnt[j] <= r_cnt[j] + 1'b1;
                end
            end
        end
    end

    assign o_was_hit = r_was_hit;
    always_comb begin
        for (int j = 0; j < NCNT; j++) begin
            o_cnt[j] = 32'(r_cnt[j]);
        end
    end

endmodule

// ===== rtl/core/set_assoc_cache_hit_miss_model_top.sv =====
`timescale 1ns / 1ps
// Set-associative cache hit/miss model. Each access transfer (kind, byte address) is looked
// up in a unified or split I/D tag store of up to 2 x 1024 sets x 16 ways; hits refresh
// recency, misses fill the lowest empty way or evict by LRU, FIFO or a 16-bit LFSR. Each
// access returns one result transfer with the hit flag and eight saturating event counters.
// An access is handled in two steps: its set row is read from the tag memory (one row
// holds all ways of a set), then compared, updated and written back, and a new access is
// taken only after the last one is committed. The next access is accepted while a result
// still waits. After reset the block clears all 2048 rows of the tag memory, one row a cycle,
// and accepts no access meanwhile; configuration writes are taken at any time but must only
// be made while the block is idle. Registers sit at byte address 4*index on the APB port.
module set_assoc_cache_hit_miss_model_top
    import sacache_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    sacache_acc_if.sink        i_acc,
    sacache_res_if.source      o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg        r_cfg;
    t_cmd        w_cmd;
    logic        w_in_ready;
    logic        w_out_valid;
    logic        w_was_hit;
    logic [31:0] w_cnt [NCNT];
    logic [2:0]  w_reg_idx;

    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;

    // configuration registers: write on the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split_mode        <= 1'b0;
            r_cfg.replace_policy    <= POL_LRU;
            r_cfg.ways_log2         <= 3'd2;
            r_cfg.offset_bits       <= 4'd6;
            r_cfg.unified_sets_log2 <= 4'd6;
            r_cfg.inst_sets_log2    <= 4'd6;
            r_cfg.data_sets_log2    <= 4'd6;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                REG_SPLIT:  r_cfg.split_mode        <= pwdata[0];
                REG_POLICY: r_cfg.replace_policy    <= pwdata[1:0];
                REG_WAYS:   r_cfg.ways_log2         <= pwdata[2:0];
                REG_OFFSET: r_cfg.offset_bits       <= pwdata[3:0];
                REG_USETS:  r_cfg.unified_sets_log2 <= pwdata[3:0];
                REG_ISETS:  r_cfg.inst_sets_log2    <= pwdata[3:0];
                REG_DSETS:  r_cfg.data_sets_log2    <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            REG_SPLIT:  prdata = 32'(r_cfg.split_mode);
            REG_POLICY: prdata = 32'(r_cfg.replace_policy);
            REG_WAYS:   prdata = 32'(r_cfg.ways_log2);
            REG_OFFSET: prdata = 32'(r_cfg.offset_bits);
            REG_USETS:  prdata = 32'(r_cfg.unified_sets_log2);
            REG_ISETS:  prdata = 32'(r_cfg.inst_sets_log2);
            REG_DSETS:  prdata = 32'(r_cfg.data_sets_log2);
            default:    prdata = 32'd0;
        endcase
    end

    // sequencer: clear sweep, accept, commit
    sacache_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_acc.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // tag store, lookup, replacement and counters
    sacache_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg          (r_cfg),
        .i_kind         (i_acc.kind),
        .i_byte_address (i_acc.byte_address),
        .o_was_hit      (w_was_hit),
        .o_cnt          (w_cnt)
    );

    assign i_acc.ready        = w_in_ready;
    assign o_res.valid        = w_out_valid;
    assign o_res.was_hit      = w_was_hit;
    assign o_res.total_hits   = w_cnt[CNT_HIT];
    assign o_res.total_misses = w_cnt[CNT_MISS];
    assign o_res.fetch_hits   = w_cnt[CNT_FETCH_HIT];
    assign o_res.fetch_misses = w_cnt[CNT_FETCH_MIS];
    assign o_res.read_hits    = w_cnt[CNT_READ_HIT];
    assign o_res.read_misses  = w_cnt[CNT_READ_MIS];
    assign o_res.write_hits   = w_cnt[CNT_WRITE_HIT];
    assign o_res.write_misses = w_cnt[CNT_WRITE_MIS];

`ifndef SYNTHESIS
    // no access is taken while the tag memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr |-> !i_acc.ready)
        else $error("access accepted during clear sweep");

    // a committed lookup always presents a result
    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_res.valid)
        else $error("commit without result");

    // an accepted access blocks the input until its lookup is committed
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc.valid && i_acc.ready) |=> !i_acc.ready)
        else $error("second access accepted while lookup pending");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import sacache_pkg::*;

    // Kind three goes to the unified or data cache and only counts in the totals.
    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ACCESSES = 182;

    typedef struct {
        logic        hit;
        logic [31:0] cnt [NCNT];
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    sacache_acc_if acc ();
    sacache_res_if res ();

    set_assoc_cache_hit_miss_model_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc.sink),
        .o_res   (res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the tag store and configuration.
    logic        shadow_valid [NBANK*MAX_SETS*MAX_WAYS];
    logic [31:0] shadow_block [NBANK*MAX_SETS*MAX_WAYS];
    logic [3:0]  shadow_rank  [NBANK*MAX_SETS*MAX_WAYS];
    logic [3:0]  shadow_fifo  [NBANK*MAX_SETS];
    logic [15:0] shadow_lfsr;
    logic [31:0] shadow_cnt   [NCNT];
    t_cfg        cur_cfg;

    t_outcome pending_results [$];
    int  fail_count;
    int  cycle_count;
    int  sent_count;
    int  checked_count;
    int  hit_seen;
    bit  gaps_on;
    logic [31:0] phase_base;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Make way w most recent; lines younger than its old rank age by one.
    function automatic void refresh_rank(int base, int ways, int w, int old_rank);
        for (int i = 0; i < ways; i++) begin
            if (i != w && shadow_valid[base+i] && int'(shadow_rank[base+i]) < old_rank
                && shadow_rank[base+i] < 4'd15)
                shadow_rank[base+i] = shadow_rank[base+i] + 4'd1;
        end
        shadow_rank[base+w] = '0;
    endfunction

    function automatic void bump(int slot);
        if (shadow_cnt[slot] != 32'hFFFF_FFFF)
            shadow_cnt[slot] = shadow_cnt[slot] + 32'd1;
    endfunction

    function automatic t_outcome lookup_access(logic [1:0] kind, logic [31:0] addr);
        t_outcome    o;
        logic [31:0] blk;
        int bank, slg, sets, ways, set_idx, sidx, base, w, best;
        bit hit, found;
        logic [15:0] l;
        blk  = addr >> cur_cfg.offset_bits;
        bank = (cur_cfg.split_mode && kind == KIND_FETCH) ? 1 : 0;
        slg  = !cur_cfg.split_mode ? int'(cur_cfg.unified_sets_log2) :
               (bank != 0 ? int'(cur_cfg.inst_sets_log2) : int'(cur_cfg.data_sets_log2));
        sets = 1 << slg;
        if (sets > MAX_SETS) sets = MAX_SETS;
        ways = 1 << int'(cur_cfg.ways_log2);
        if (ways > MAX_WAYS) ways = MAX_WAYS;
        set_idx = int'(blk % sets);
        sidx = bank * MAX_SETS + set_idx;
        base = sidx * MAX_WAYS;
        hit = 0;
        found = 0;
        w = 0;
        for (int i = 0; i < ways; i++) begin
            if (!hit && shadow_valid[base+i] && shadow_block[base+i] == blk) begin
                hit = 1;
                w = i;
            end
        end
        if (hit) begin
            refresh_rank(base, ways, w, int'(shadow_rank[base+w]));
        end else begin
            for (int i = 0; i < ways; i++) begin
                if (!found && !shadow_valid[base+i]) begin
                    found = 1;
                    w = i;
                end
            end
            if (found) begin
                shadow_valid[base+w] = 1'b1;
                shadow_block[base+w] = blk;
                refresh_rank(base, ways, w, 16);
            end else begin
                if (cur_cfg.replace_policy == POL_FIFO) begin
                    w = int'(shadow_fifo[sidx]) % ways;
                    shadow_fifo[sidx] = 4'((w + 1) % ways);
                end else if (cur_cfg.replace_policy == POL_RAND) begin
                    l = shadow_lfsr;
                    shadow_lfsr = l[0] ? ((l >> 1) ^ LFSR_TAPS) : (l >> 1);
                    w = int'(shadow_lfsr) % ways;
                end else begin
                    best = 0;
                    w = 0;
                    for (int i = 0; i < ways; i++) begin
                        if (int'(shadow_rank[base+i]) > best) begin
                            best = int'(shadow_rank[base+i]);
                            w = i;
                        end
                    end
                end
                shadow_block[base+w] = blk;
                refresh_rank(base, ways, w, int'(shadow_rank[base+w]));
            end
        end
        if (hit) begin
            bump(CNT_HIT);
            if (kind == KIND_FETCH) bump(CNT_FETCH_HIT);
            else if (kind == KIND_READ) bump(CNT_READ_HIT);
            else if (kind == KIND_WRITE) bump(CNT_WRITE_HIT);
        end else begin
            bump(CNT_MISS);
            if (kind == KIND_FETCH) bump(CNT_FETCH_MIS);
            else if (kind == KIND_READ) bump(CNT_READ_MIS);
            else if (kind == KIND_WRITE) bump(CNT_WRITE_MIS);
        end
        o.hit = hit;
        for (int j = 0; j < NCNT; j++) o.cnt[j] = shadow_cnt[j];
        return o;
    endfunction

    // Send one access; valid stays high afterwards so back-to-back transfers need no gap.
    task automatic send_access(logic [1:0] kind, logic [31:0] addr);
        t_outcome exp_res;
        acc.valid        <= 1'b1;
        acc.kind         <= kind;
        acc.byte_address <= addr;
        @(posedge i_clk);
        while (!acc.ready) @(posedge i_clk);
        exp_res = lookup_access(kind, addr);
        pending_results.insert(pending_results.size(), exp_res);
        sent_count++;
    endtask

    task automatic hold_sender(int n);
        acc.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drain all results, then let the pipeline settle before touching registers.
    task automatic wait_drained();
        acc.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register is written at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SPLIT:  cur_cfg.split_mode        = value[0];
            REG_POLICY: cur_cfg.replace_policy    = value[1:0];
            REG_WAYS:   cur_cfg.ways_log2         = value[2:0];
            REG_OFFSET: cur_cfg.offset_bits       = value[3:0];
            REG_USETS:  cur_cfg.unified_sets_log2 = value[3:0];
            REG_ISETS:  cur_cfg.inst_sets_log2    = value[3:0];
            REG_DSETS:  cur_cfg.data_sets_log2    = value[3:0];
            default: ;
        endcase
        // bus returns to idle between transfers
        @(posedge i_clk);
    endtask

    task automatic apply_cfg(t_cfg c);
        wait_drained();
        write_reg(REG_SPLIT,  32'(c.split_mode));
        write_reg(REG_POLICY, 32'(c.replace_policy));
        write_reg(REG_WAYS,   32'(c.ways_log2));
        write_reg(REG_OFFSET, 32'(c.offset_bits));
        write_reg(REG_USETS,  32'(c.unified_sets_log2));
        write_reg(REG_ISETS,  32'(c.inst_sets_log2));
        write_reg(REG_DSETS,  32'(c.data_sets_log2));
    endtask

    // Mostly a small pool of blocks packed into few sets so lines hit and get evicted;
    // the rest are fully random addresses.
    function automatic logic [31:0] pick_address();
        logic [31:0] blk;
        if ($urandom_range(0, 9) < 8) begin
            blk = phase_base ^ (($urandom_range(0, 23) << 10) | $urandom_range(0, 3));
            return (blk << cur_cfg.offset_bits)
                   | ($urandom & ((32'd1 << cur_cfg.offset_bits) - 32'd1));
        end
        return $urandom;
    endfunction

    // Result side: random stalls in bursts, released for the last phase.
    initial begin
        res.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (gaps_on && $urandom_range(0, 2) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // Compare every result transfer field by field with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_outcome    e;
        logic [31:0] got [NCNT];
        if (i_rst_n && res.valid && res.ready) begin
            got[CNT_HIT]       = res.total_hits;
            got[CNT_MISS]      = res.total_misses;
            got[CNT_FETCH_HIT] = res.fetch_hits;
            got[CNT_FETCH_MIS] = res.fetch_misses;
            got[CNT_READ_HIT]  = res.read_hits;
            got[CNT_READ_MIS]  = res.read_misses;
            got[CNT_WRITE_HIT] = res.write_hits;
            got[CNT_WRITE_MIS] = res.write_misses;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected (hit %0b)", $time, res.was_hit);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                checked_count++;
                if (res.was_hit) hit_seen++;
                if (res.was_hit !== e.hit) begin
                    $display("%0t: was_hit expected %0b actual %0b", $time, e.hit, res.was_hit);
                    fail_count++;
                end
                for (int j = 0; j < NCNT; j++) begin
                    if (got[j] !== e.cnt[j]) begin
                        $display("%0t: counter %0d expected %0d actual %0d",
                                 $time, j, e.cnt[j], got[j]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Default geometry: extremes of address and kind, fill and evict one set by LRU.
    task automatic test_directed_defaults();
        send_access(KIND_READ, 32'h0000_0000);
        send_access(KIND_READ, 32'h0000_003F);
        send_access(KIND_WRITE, 32'hFFFF_FFFF);
        send_access(KIND_FETCH, 32'hFFFF_FFC0);
        send_access(KIND_OTHER, 32'h0000_0010);
        send_access(KIND_OTHER, 32'h1234_5678);
        // five blocks into set 0 of a four-way cache
        for (int i = 1; i <= 5; i++) send_access(KIND_READ, 32'(i << 12));
        send_access(KIND_WRITE, 32'h0000_1000);
        send_access(KIND_FETCH, 32'h0000_5000);
        send_access(KIND_READ, 32'hAAAA_AAAA);
        send_access(KIND_WRITE, 32'h5555_5555);
    endtask

    // Split caches, FIFO and random victims, one way and the largest geometry.
    task automatic test_directed_policies();
        t_cfg c;
        c = '{split_mode: 1'b1, replace_policy: POL_FIFO, ways_log2: 3'd0, offset_bits: 4'd0,
              unified_sets_log2: 4'd0, inst_sets_log2: 4'd0, data_sets_log2: 4'd10};
        apply_cfg(c);
        for (int i = 0; i < 3; i++) send_access(KIND_FETCH, 32'(i));
        send_access(KIND_FETCH, 32'd2);
        send_access(KIND_READ, 32'd2);
        c = '{split_mode: 1'b0, replace_policy: POL_RAND, ways_log2: 3'd1, offset_bits: 4'd12,
              unified_sets_log2: 4'd0, inst_sets_log2: 4'd10, data_sets_log2: 4'd0};
        apply_cfg(c);
        for (int i = 0; i < 5; i++) send_access(KIND_WRITE, 32'(i << 12));
        c.ways_log2 = 3'd4;
        c.unified_sets_log2 = 4'd10;
        c.offset_bits = 4'd0;
        apply_cfg(c);
        send_access(KIND_READ, 32'hFFFF_FFFF);
        send_access(KIND_READ, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic();
        t_cfg c;
        for (int p = 0; p < RAND_PHASES; p++) begin
            c.split_mode        = 1'($urandom_range(0, 1));
            c.replace_policy    = 2'($urandom_range(0, 2));
            c.ways_log2         = 3'($urandom_range(0, 4));
            c.offset_bits       = 4'($urandom_range(0, 12));
            c.unified_sets_log2 = 4'($urandom_range(0, 10));
            c.inst_sets_log2    = 4'($urandom_range(0, 10));
            c.data_sets_log2    = 4'($urandom_range(0, 10));
            // pin the extremes on the early phases
            if (p == 0) begin
                c.ways_log2 = 3'd4;
                c.offset_bits = 4'd12;
                c.unified_sets_log2 = 4'd10;
            end
            if (p == 1) begin
                c.ways_log2 = 3'd0;
                c.offset_bits = 4'd0;
                c.inst_sets_log2 = 4'd0;
                c.data_sets_log2 = 4'd0;
            end
            apply_cfg(c);
            phase_base = $urandom;
            gaps_on = (p != RAND_PHASES - 1);
            for (int i = 0; i < PHASE_ACCESSES; i++) begin
                if (gaps_on && $urandom_range(0, 3) == 0) hold_sender($urandom_range(1, 12));
                // hold off once mid-phase until every result is back
                if (p == 2 && i == PHASE_ACCESSES / 2) wait_drained();
                send_access(2'($urandom_range(0, 3)), pick_address());
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        acc.valid = 1'b0;
        acc.kind = KIND_READ;
        acc.byte_address = '0;
        fail_count = 0;
        cycle_count = 0;
        sent_count = 0;
        checked_count = 0;
        hit_seen = 0;
        gaps_on = 1'b1;
        phase_base = '0;
        cur_cfg = '{split_mode: 1'b0, replace_policy: POL_LRU, ways_log2: 3'd2,
                    offset_bits: 4'd6, unified_sets_log2: 4'd6, inst_sets_log2: 4'd6,
                    data_sets_log2: 4'd6};
        for (int i = 0; i < NBANK*MAX_SETS*MAX_WAYS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_block[i] = '0;
            shadow_rank[i] = '0;
        end
        for (int i = 0; i < NBANK*MAX_SETS; i++) shadow_fifo[i] = '0;
        for (int j = 0; j < NCNT; j++) shadow_cnt[j] = '0;
        shadow_lfsr = LFSR_SEED;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_directed_policies();
        test_random_traffic();

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered %0d accesses, %0d results checked, %0d hits, over %0d geometries",
                 sent_count, checked_count, hit_seen, RAND_PHASES + 4);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending_results.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
